// ===== hw/rtl/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; the decoder modules and the testbench import this package.
package u8d_pkg;

	localparam int CP_W    = 26;
	localparam int LEN_W   = 3;
	localparam int NUM_W   = 16;
	localparam int ACC_W   = 24;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [7:0]       NUL_BYTE    = 8'h00;
	localparam logic [1:0]       CONT_TAG    = 2'b10;
	localparam logic [NUM_W-1:0] NUM_MAX     = 16'hFFFF;

	typedef logic [CP_W-1:0]  cp_t;
	typedef logic [LEN_W-1:0] len_t;

	// One request from the front: an optional flushed character, an optional
	// new character, and a counter clear that follows the flush.
	typedef struct packed {
		logic flush_v;
		cp_t  flush_cp;
		len_t flush_len;
		logic main_v;
		cp_t  main_cp;
		len_t main_len;
		logic clr;
	} u8d_req_t;

endpackage

// ===== hw/rtl/u8d_byte_if.sv =====
// Input channel of the UTF-8 stream decoder: one string byte per request.
// Depends on nothing.
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/u8d_char_if.sv =====
// Output channel of the UTF-8 stream decoder: one decoded character per request.
// Depends on nothing.
interface u8d_char_if;
	logic        valid;
	logic        ready;
	logic [25:0] code_point;
	logic [2:0]  byte_length;
	logic [15:0] char_number;
	logic        last_of_run;

	modport source (output valid, output code_point, output byte_length,
		output char_number, output last_of_run, input ready);
	modport sink   (input valid, input code_point, input byte_length,
		input char_number, input last_of_run, output ready);
endinterface

// ===== hw/rtl/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder, legacy one- to six-byte lead bytes.
// Channel in takes one byte of a zero-terminated string per request; channel
// out gives one decoded character per request: code point, byte length,
// 1-based character number (saturating) and a flag on the last character
// caused by a given input byte.
// A byte is taken in every clock while the four-entry request queue between
// front and back has room. A byte passes through the request queue and the
// output register before the character that it completes leaves. A byte that
// both ends a pending character and forms a new one yields two results, which
// the back emits one after the other; every character uses at least one byte
// of its own, so while the receiver takes a character per clock the queue
// never fills and bytes are taken back to back.
// A zero byte emits any pending character and clears the character counter.
// When the receiver holds ready low, the output register keeps its character,
// the queue fills and then the input stalls; nothing is dropped.
// Reset clears the pending character, counter, queue and output valid.
// Depends on u8d_pkg, u8d_byte_if, u8d_char_if, u8d_front, u8d_queue, u8d_back.
module utf8_stream_decoder_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	u8d_byte_if.sink   in,
	u8d_char_if.source out
);
	import u8d_pkg::*;

	logic     push;
	logic     not_full;
	logic     pop;
	logic     head_valid;
	u8d_req_t push_req;
	u8d_req_t head;

	u8d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in      (in),
		.q_ready (not_full),
		.push    (push),
		.req     (push_req)
	);

	u8d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.not_full   (not_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	u8d_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out        (out)
	);

endmodule

// ===== hw/rtl/u8d_front.sv =====
// Front of the decoder: accepts bytes, tracks the pending character and
// builds requests for the back. Depends on u8d_pkg and u8d_byte_if.
module u8d_front (
	input  logic              clk,
	input  logic              arst_n,
	u8d_byte_if.sink          in,
	input  logic              q_ready,
	output logic              push,
	output u8d_pkg::u8d_req_t req
);
	import u8d_pkg::*;

	logic [2:0]       cnt_q, cnt_n;
	logic [2:0]       exp_q, exp_n;
	logic [7:0]       b0_q, b0_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [ACC_W-1:0] acc_ext;
	logic [2:0]       cnt_inc;
	logic [2:0]       lead_len;
	logic             pending;
	logic             take;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] n;
		case (b) inside
			8'b110?????: n = 3'd2;
			8'b1110????: n = 3'd3;
			8'b11110???: n = 3'd4;
			8'b111110??: n = 3'd5;
			8'b1111110?: n = 3'd6;
			default:     n = 3'd1;
		endcase
		return n;
	endfunction

	// Masked shifts for the actual length; acc holds continuation payloads low-aligned.
	function automatic cp_t cp_of(input logic [7:0] b0, input logic [ACC_W-1:0] acc,
		input len_t len);
		cp_t cp;
		case (len)
			3'd1:    cp = {18'd0, b0};
			3'd2:    cp = {15'd0, b0[4:0], acc[5:0]};
			3'd3:    cp = {10'd0, b0[3:0], acc[11:0]};
			3'd4:    cp = {5'd0, b0[2:0], acc[17:0]};
			3'd5:    cp = {b0[1:0], acc[23:0]};
			default: cp = '0;
		endcase
		return cp;
	endfunction

	assign in.ready = q_ready;
	assign take     = in.valid && q_ready;
	assign pending  = (cnt_q != 3'd0);
	assign acc_ext  = {acc_q[ACC_W-7:0], in.data_byte[5:0]};
	assign cnt_inc  = cnt_q + 3'd1;
	assign lead_len = lead_length(in.data_byte);

	// Classify the byte and decide results and next pending state
	always_comb begin
		req   = '0;
		cnt_n = cnt_q;
		exp_n = exp_q;
		b0_n  = b0_q;
		acc_n = acc_q;
		if (in.data_byte == NUL_BYTE) begin
			req.flush_v   = pending;
			req.flush_cp  = cp_of(b0_q, acc_q, cnt_q);
			req.flush_len = cnt_q;
			req.clr       = 1'b1;
			cnt_n         = 3'd0;
			exp_n         = 3'd0;
		end else if (in.data_byte[7:6] == CONT_TAG) begin
			if (!pending) begin
				req.main_v   = 1'b1;
				req.main_cp  = {18'd0, in.data_byte};
				req.main_len = 3'd1;
			end else if (cnt_inc >= exp_q) begin
				req.main_v   = 1'b1;
				req.main_cp  = cp_of(b0_q, acc_ext, cnt_inc);
				req.main_len = cnt_inc;
				cnt_n        = 3'd0;
				exp_n        = 3'd0;
			end else begin
				acc_n = acc_ext;
				cnt_n = cnt_inc;
			end
		end else begin
			req.flush_v   = pending;
			req.flush_cp  = cp_of(b0_q, acc_q, cnt_q);
			req.flush_len = cnt_q;
			if (lead_len == 3'd1) begin
				req.main_v   = 1'b1;
				req.main_cp  = {18'd0, in.data_byte};
				req.main_len = 3'd1;
				cnt_n        = 3'd0;
				exp_n        = 3'd0;
			end else begin
				b0_n  = in.data_byte;
				acc_n = '0;
				cnt_n = 3'd1;
				exp_n = lead_len;
			end
		end
	end

	assign push = take && (req.flush_v || req.main_v || req.clr);

	// Advance pending-character state on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			exp_q <= 3'd0;
		end else if (take) begin
			cnt_q <= cnt_n;
			exp_q <= exp_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			b0_q  <= b0_n;
			acc_q <= acc_n;
		end
	end

endmodule

// ===== hw/rtl/u8d_queue.sv =====
// Small request queue between front and back of the decoder.
// Depends on u8d_pkg.
module u8d_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8d_pkg::u8d_req_t push_req,
	output logic              not_full,
	input  logic              pop,
	output logic              head_valid,
	output u8d_pkg::u8d_req_t head
);
	import u8d_pkg::*;

	u8d_req_t             entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign not_full   = (fill_q != Q_CNT_W'(Q_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (do_push && !do_pop)      fill_q <= fill_q + Q_CNT_W'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - Q_CNT_W'(1);
		end
	end

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_req;
	end

endmodule

// ===== hw/rtl/u8d_back.sv =====
// Back of the decoder: serializes queued requests, numbers characters and
// holds the output register. Depends on u8d_pkg and u8d_char_if.
module u8d_back #(
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  u8d_pkg::u8d_req_t head,
	output logic              pop,
	u8d_char_if.source        out
);
	import u8d_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [NUM_W-1:0]      num_clamp;
	logic                  phase_q;
	logic                  ovalid_q;
	cp_t                   cp_q;
	len_t                  len_q;
	logic [NUM_W-1:0]      num_q;
	logic                  last_q;
	logic                  load_ok;
	logic                  step;
	logic                  emit_flush;

	assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);

	// Clamp the character number to the output width
	if (COUNT_BITS > NUM_W) begin : g_wide
		assign num_clamp = (|cnt_inc[COUNT_BITS-1:NUM_W]) ? NUM_MAX : cnt_inc[NUM_W-1:0];
	end else begin : g_narrow
		assign num_clamp = NUM_W'(cnt_inc);
	end

	assign load_ok    = !ovalid_q || out.ready;
	assign step       = head_valid && load_ok;
	assign emit_flush = head.flush_v && !phase_q;
	assign pop        = step && !(emit_flush && head.main_v);

	// Emit the flushed character first, then the new one; a clear resets the counter once the flushed one is numbered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			phase_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (step && (emit_flush || head.main_v)) begin
				ovalid_q <= 1'b1;
			end else if (out.ready) begin
				ovalid_q <= 1'b0;
			end
			if (step) begin
				if (emit_flush) begin
					cnt_q    <= head.clr ? '0 : cnt_inc;
					phase_q  <= head.main_v;
				end else if (head.main_v) begin
					cnt_q    <= cnt_inc;
					phase_q  <= 1'b0;
				end else begin
					cnt_q    <= '0;
					phase_q  <= 1'b0;
				end
			end
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (step && emit_flush) begin
			cp_q   <= head.flush_cp;
			len_q  <= head.flush_len;
			num_q  <= num_clamp;
			last_q <= !head.main_v;
		end else if (step && head.main_v) begin
			cp_q   <= head.main_cp;
			len_q  <= head.main_len;
			num_q  <= num_clamp;
			last_q <= 1'b1;
		end
	end

	assign out.valid       = ovalid_q;
	assign out.code_point  = cp_q;
	assign out.byte_length = len_q;
	assign out.char_number = num_q;
	assign out.last_of_run = last_q;

endmodule

// ===== test/tb_utf8_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_decoder_core: drives string bytes and predicts
// each decoded character, then checks every field of each character that leaves.
// Depends on u8d_pkg, u8d_byte_if, u8d_char_if and the decoder RTL.
module tb_utf8_stream_decoder_core;
	import u8d_pkg::*;

	localparam int CNT_BITS = 16;
	localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_BYTES = 550;

	// Opening bytes: terminator with nothing pending, a plain ASCII byte, a stray
	// continuation, 0xFE/0xFF, full 2/3/4/6-byte characters, a lead cut short
	// by a plain byte, and a lone lead flushed by the terminator.
	localparam logic [0:23][7:0] OPENING = {
		8'h00, 8'h41, 8'h80, 8'hFE, 8'hFF,
		8'hC2, 8'hA9,
		8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h9F, 8'h98, 8'h80,
		8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80,
		8'hE2, 8'h41,
		8'hC3, 8'h00
	};

	typedef struct packed {
		cp_t              cp;
		len_t             len;
		logic [NUM_W-1:0] num;
		logic             last;
	} char_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	u8d_byte_if byte_ch ();
	u8d_char_if char_ch ();

	utf8_stream_decoder_core #(
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (byte_ch.sink),
		.out   (char_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [7:0]      bytes_to_send [$];
	char_rec_t       chars_due [$];
	int              send_gap_pct;
	int              recv_gap_pct;
	int              hold_orders = 0;
	int              errors = 0;

	// Decoder state as the predictor sees it
	logic [4:0][7:0] pend = '0;
	int              pend_cnt = 0;
	int              want_len = 0;
	longint unsigned char_cnt = 0;
	int              run_len;

	// Code point from masked shifts, chosen by the actual byte count
	function automatic cp_t fold_bits(input logic [5:0][7:0] u, input int n);
		case (n)
		1: return cp_t'(u[0]);
		2: return cp_t'({u[0][4:0], u[1][5:0]});
		3: return cp_t'({u[0][3:0], u[1][5:0], u[2][5:0]});
		4: return cp_t'({u[0][2:0], u[1][5:0], u[2][5:0], u[3][5:0]});
		5: return {u[0][1:0], u[1][5:0], u[2][5:0], u[3][5:0], u[4][5:0]};
		default: return '0;
		endcase
	endfunction

	function automatic int lead_span(input logic [7:0] b);
		casez (b)
		8'b110?????: return 2;
		8'b1110????: return 3;
		8'b11110???: return 4;
		8'b111110??: return 5;
		8'b1111110?: return 6;
		default: return 1;
		endcase
	endfunction

	// Count the character (saturating) and queue it as due
	function automatic void post_char(input cp_t cp, input int n);
		char_rec_t r;
		if (char_cnt < CNT_MAX)
			char_cnt++;
		r.cp = cp;
		r.len = len_t'(n);
		r.num = (char_cnt > 64'hFFFF) ? NUM_MAX : NUM_W'(char_cnt);
		r.last = 1'b0;
		chars_due.push_back(r);
		run_len++;
	endfunction

	function automatic void flush_pending();
		if (pend_cnt != 0) begin
			post_char(fold_bits({8'h00, pend}, pend_cnt), pend_cnt);
			pend_cnt = 0;
			want_len = 0;
		end
	endfunction

	// Advance the predictor by one accepted byte
	function automatic void take_byte(input logic [7:0] b);
		logic [5:0][7:0] u;
		int span;
		char_rec_t tail;
		run_len = 0;
		if (b == NUL_BYTE) begin
			flush_pending();
			char_cnt = 0;
		end else if (b[7:6] == CONT_TAG) begin
			if (pend_cnt == 0) begin
				post_char(cp_t'(b), 1);
			end else if (pend_cnt + 1 >= want_len) begin
				u = {8'h00, pend};
				u[pend_cnt] = b;
				post_char(fold_bits(u, pend_cnt + 1), pend_cnt + 1);
				pend_cnt = 0;
				want_len = 0;
			end else begin
				pend[pend_cnt] = b;
				pend_cnt++;
			end
		end else begin
			flush_pending();
			span = lead_span(b);
			if (span == 1) begin
				post_char(cp_t'(b), 1);
			end else begin
				pend[0] = b;
				pend_cnt = 1;
				want_len = span;
			end
		end
		// Flag the final character caused by this byte
		if (run_len != 0) begin
			tail = chars_due.pop_back();
			tail.last = 1'b1;
			chars_due.push_back(tail);
		end
	endfunction

	// Queue a lead byte announcing span bytes, followed by n-1 continuations
	function automatic void push_char(input int span, input int n);
		logic [7:0] lead;
		lead = 8'($urandom);
		case (span)
		1: lead = 8'($urandom_range(1, 127));
		2: lead[7:5] = 3'b110;
		3: lead[7:4] = 4'b1110;
		4: lead[7:3] = 5'b11110;
		5: lead[7:2] = 6'b111110;
		default: lead[7:1] = 7'b1111110;
		endcase
		bytes_to_send.push_back(lead);
		for (int i = 1; i < n; i++)
			bytes_to_send.push_back({CONT_TAG, 6'($urandom)});
	endfunction

	// Mostly well-formed text, with terminators, cut-short characters and noise
	task automatic queue_text(input int count);
		int sent;
		int pick;
		int span;
		int cut;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				bytes_to_send.push_back(NUL_BYTE);
				sent++;
			end else if (pick < 75) begin
				span = $urandom_range(0, 15);
				span = (span < 6) ? 1 : (span < 10) ? 2 : (span < 13) ? 3 :
					(span == 13) ? 4 : (span == 14) ? 5 : 6;
				push_char(span, span);
				sent += span;
			end else if (pick < 87) begin
				span = $urandom_range(2, 6);
				cut = $urandom_range(1, span - 1);
				push_char(span, cut);
				sent += cut;
			end else begin
				bytes_to_send.push_back(8'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	// Hold until every queued byte is taken and every due character has left
	task automatic wait_idle();
		do
			@(negedge clk);
		while (bytes_to_send.size() != 0 || byte_ch.valid || chars_due.size() != 0);
	endtask

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			errors++;
		end
	endfunction

	// Byte driver: offer the next queued byte, predict on each accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data_byte <= '0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (byte_ch.valid)
				take_byte(byte_ch.data_byte);
			if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				byte_ch.valid <= 1'b1;
				byte_ch.data_byte <= bytes_to_send.pop_front();
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// Character receiver: random stalls, plus a long hold-off on request
	int hold_seen;
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_ch.ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_orders) begin
			hold_seen <= hold_orders;
			hold_left <= HOLD_CYCLES;
			char_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			char_ch.ready <= 1'b0;
		end else begin
			char_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	// Character monitor: compare each accepted request with the oldest due one
	always @(posedge clk) begin
		char_rec_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (chars_due.size() == 0) begin
				$error("unexpected character: code_point 0x%0h byte_length %0d",
					char_ch.code_point, char_ch.byte_length);
				errors++;
			end else begin
				want = chars_due.pop_front();
				check_field("code_point", 32'(want.cp), 32'(char_ch.code_point));
				check_field("byte_length", 32'(want.len), 32'(char_ch.byte_length));
				check_field("char_number", 32'(want.num), 32'(char_ch.char_number));
				check_field("last_of_run", 32'(want.last), 32'(char_ch.last_of_run));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		send_gap_pct = 29;
		recv_gap_pct = 56;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 24; i++)
			bytes_to_send.push_back(OPENING[i]);
		queue_text(PHASE_BYTES);
		wait_idle();

		// Swap the idle rates
		send_gap_pct = 56;
		recv_gap_pct = 29;
		queue_text(PHASE_BYTES);
		wait_idle();

		// Stall the output long enough to back up the input
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_orders++;
		queue_text(150);
		wait_idle();

		queue_text(PHASE_BYTES);
		wait_idle();

		// Close with a full character, a terminator and a plain byte
		push_char(3, 3);
		bytes_to_send.push_back(NUL_BYTE);
		bytes_to_send.push_back(8'h41);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_byte_if.sv
hw/rtl/u8d_char_if.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_stream_decoder_core.sv
test/tb_utf8_stream_decoder_core.sv
